@@ src/uartrx_pkg.sv @@
// Shared request codes, character constants and count limits for the serial receive line buffer.
// No dependencies.
package uartrx_pkg;

    localparam logic [1:0] REQ_RECV  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [5:0] COUNT_MAX = 6'd63;
    localparam logic [6:0] LIMIT_MAX = 7'd64;

endpackage

@@ src/uart_rx_line_buffer.sv @@
// Top level of the serial receive line buffer: byte ring in one synchronous memory.
// Depends on uartrx_pkg.
//
// A received byte or a count query is accepted back to back while the result
// register is free; a received byte with any error flag set is dropped, and a
// full ring overwrites its oldest byte. A read-line request pops its bytes
// (terminator included) until a CR or LF ends it, the ring runs empty or the line
// limit is reached, and it waits whenever the result side stalls: the store has a
// single registered read port, and the head byte is prefetched, so one byte leaves
// the ring per cycle while the result side does not stall. Each popped byte is held
// back until the next head byte is seen, so that its last flag is known when shown.
// No new item is accepted while a line read is in progress.
module uart_rx_line_buffer
    import uartrx_pkg::*;
#(
    parameter int RX_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic       i_parity_err,
    input  logic       i_framing_err,
    input  logic       i_noise_err,
    input  logic       i_overrun_err,
    input  logic [6:0] i_line_limit,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic [5:0] o_line_count,
    output logic       o_line_done,
    output logic [5:0] o_avail_count,
    output logic       o_last
);

    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = (PW > 6) ? PW : 6;
    localparam logic [PW-1:0] PTR_LAST = PW'(RX_DEPTH - 1);
    localparam logic [PW-1:0] PTR_SPAN = PW'(RX_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_mem_q;
    logic          r_byp;
    logic [7:0]    r_byp_data;

    logic          r_state, n_state;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [5:0]    r_n, n_n;
    logic [5:0]    r_max, n_max;
    logic          r_pend, n_pend;
    logic [7:0]    r_pchar, n_pchar;

    logic          r_o_valid, n_o_valid;
    logic [7:0]    r_o_char, n_o_char;
    logic          r_o_cv, n_o_cv;
    logic [5:0]    r_o_cnt, n_o_cnt;
    logic          r_o_done, n_o_done;
    logic [5:0]    r_o_avail, n_o_avail;
    logic          r_o_last, n_o_last;

    logic          w_acc;
    logic          w_out_free;
    logic          w_wr_en;
    logic          w_bad;
    logic [7:0]    w_head;
    logic [PW-1:0] w_wr_next;
    logic [PW-1:0] w_rd_next;
    logic [PW-1:0] w_cnt;
    logic [CW-1:0] w_cnt_ext;
    logic          w_term;
    logic          w_stop;

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_acc      = i_valid && !o_stall;
    assign w_bad      = i_parity_err || i_framing_err || i_noise_err || i_overrun_err;
    assign w_wr_en    = w_acc && (i_req_type == REQ_RECV) && !w_bad;

    assign w_wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign w_cnt     = (r_wr_ptr >= r_rd_ptr) ? (r_wr_ptr - r_rd_ptr)
                                              : (PTR_SPAN - r_rd_ptr + r_wr_ptr);
    assign w_cnt_ext = CW'(w_cnt);

    assign w_head = r_byp ? r_byp_data : r_mem_q;
    assign w_term = (w_head == CHAR_LF) || (w_head == CHAR_CR);
    assign w_stop = (r_wr_ptr == r_rd_ptr) || (r_n == r_max);

    always_comb begin
        n_state   = r_state;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_n       = r_n;
        n_max     = r_max;
        n_pend    = r_pend;
        n_pchar   = r_pchar;
        n_o_valid = r_o_valid && i_stall;
        n_o_char  = r_o_char;
        n_o_cv    = r_o_cv;
        n_o_cnt   = r_o_cnt;
        n_o_done  = r_o_done;
        n_o_avail = r_o_avail;
        n_o_last  = r_o_last;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req_type)
                        REQ_RECV: begin
                            if (!w_bad) begin
                                n_wr_ptr = w_wr_next;
                                if (w_wr_next == r_rd_ptr) begin
                                    n_rd_ptr = w_rd_next;
                                end
                            end
                        end
                        REQ_READ: begin
                            n_state = S_READ;
                            n_n     = '0;
                            n_pend  = 1'b0;
                            if (i_line_limit == 7'd0) begin
                                n_max = '0;
                            end else if (i_line_limit >= LIMIT_MAX) begin
                                n_max = COUNT_MAX;
                            end else begin
                                n_max = 6'(i_line_limit - 7'd1);
                            end
                        end
                        REQ_QUERY: begin
                            n_o_valid = 1'b1;
                            n_o_char  = '0;
                            n_o_cv    = 1'b0;
                            n_o_cnt   = '0;
                            n_o_done  = 1'b0;
                            n_o_last  = 1'b1;
                            if (w_cnt_ext > CW'(COUNT_MAX)) begin
                                n_o_avail = COUNT_MAX;
                            end else begin
                                n_o_avail = 6'(w_cnt_ext);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_o_avail = '0;
                    if (w_stop || w_term) begin
                        // final result: held byte or an empty line
                        n_o_valid = 1'b1;
                        n_o_char  = r_pend ? r_pchar : 8'd0;
                        n_o_cv    = r_pend;
                        n_o_cnt   = r_pend ? r_n : 6'd0;
                        n_o_done  = !w_stop;
                        n_o_last  = 1'b1;
                        n_state   = S_IDLE;
                        if (!w_stop) begin
                            n_rd_ptr = w_rd_next;
                        end
                    end else begin
                        n_rd_ptr = w_rd_next;
                        if (r_pend) begin
                            n_o_valid = 1'b1;
                            n_o_char  = r_pchar;
                            n_o_cv    = 1'b1;
                            n_o_cnt   = r_n;
                            n_o_done  = 1'b0;
                            n_o_last  = 1'b0;
                        end
                        n_pend  = 1'b1;
                        n_pchar = w_head;
                        n_n     = r_n + 6'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store, head prefetch at the next read pointer, bypass for same-entry write
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
        r_mem_q    <= r_mem[n_rd_ptr];
        r_byp_data <= i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_n       <= '0;
            r_max     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_n       <= n_n;
            r_max     <= n_max;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            r_byp     <= w_wr_en && (r_wr_ptr == n_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pchar   <= n_pchar;
        r_o_char  <= n_o_char;
        r_o_cv    <= n_o_cv;
        r_o_cnt   <= n_o_cnt;
        r_o_done  <= n_o_done;
        r_o_avail <= n_o_avail;
        r_o_last  <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_out_char    = r_o_char;
    assign o_char_valid  = r_o_cv;
    assign o_line_count  = r_o_cnt;
    assign o_line_done   = r_o_done;
    assign o_avail_count = r_o_avail;
    assign o_last        = r_o_last;

endmodule

@@ src/uartrx_chk.sv @@
// Port-level checker for the serial receive line buffer, bound to the top level.
// Depends on uart_rx_line_buffer.
module uartrx_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_char_valid,
    input logic [5:0] o_line_count,
    input logic       o_line_done,
    input logic [5:0] o_avail_count,
    input logic       o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last))
        else $error("result changed while stalled");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_line_count == 6'd0 && o_last)
        else $error("result without byte has count or is not final");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_valid |-> o_line_count != 6'd0 && o_avail_count == 6'd0)
        else $error("byte result with bad count fields");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_done |-> o_last && o_avail_count == 6'd0)
        else $error("line end flag on a non-final result");

endmodule

bind uart_rx_line_buffer uartrx_chk u_uartrx_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_char    (o_out_char),
    .o_char_valid  (o_char_valid),
    .o_line_count  (o_line_count),
    .o_line_done   (o_line_done),
    .o_avail_count (o_avail_count),
    .o_last        (o_last)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for uart_rx_line_buffer: directed and random requests,
// predicted results checked in order, random idling and stalls on both channels.
// Depends on uartrx_pkg and the uart_rx_line_buffer RTL.
module tb_top;
    import uartrx_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 180;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
        logic       par;
        logic       frm;
        logic       noi;
        logic       ovr;
        logic [6:0] limit;
    } rx_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_ok;
        logic [5:0] count;
        logic       done;
        logic [5:0] avail;
        logic       last;
    } line_resp_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_rx_byte = '0;
    logic       i_parity_err = 1'b0;
    logic       i_framing_err = 1'b0;
    logic       i_noise_err = 1'b0;
    logic       i_overrun_err = 1'b0;
    logic [6:0] i_line_limit = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic [5:0] o_line_count;
    logic       o_line_done;
    logic [5:0] o_avail_count;
    logic       o_last;

    rx_req_t    pending_reqs[$];
    line_resp_t line_resp_q[$];

    logic [7:0] line_ring[64];
    logic [5:0] ring_wr = '0;
    logic [5:0] ring_rd = '0;

    int  counted_items = 0;
    int  accepted_items = 0;
    int  miss_count = 0;
    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    uart_rx_line_buffer DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_rx_byte(i_rx_byte),
        .i_parity_err(i_parity_err),
        .i_framing_err(i_framing_err),
        .i_noise_err(i_noise_err),
        .i_overrun_err(i_overrun_err),
        .i_line_limit(i_line_limit),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_char(o_out_char),
        .o_char_valid(o_char_valid),
        .o_line_count(o_line_count),
        .o_line_done(o_line_done),
        .o_avail_count(o_avail_count),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and stretches with none at all.
    function automatic int draw_gap(ref bit steady);
        int r;
        if ($urandom_range(0, 29) == 0) steady = !steady;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    task automatic queue_item(input rx_req_t r);
        pending_reqs.push_back(r);
        counted_items++;
    endtask

    task automatic push_recv(input logic [7:0] b, input logic [3:0] errs);
        queue_item('{REQ_RECV, b, errs[3], errs[2], errs[1], errs[0], 7'($urandom)});
    endtask

    task automatic push_read(input logic [6:0] lim);
        queue_item('{REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom), lim});
    endtask

    task automatic push_query();
        queue_item('{REQ_QUERY, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom), 7'($urandom)});
    endtask

    task automatic predict_buffer(input rx_req_t r);
        logic [6:0] lim;
        logic [5:0] n;
        logic [7:0] c;
        int         maxb;
        bit         done;
        bit         stop;
        line_resp_t resp;
        case (r.req)
            REQ_RECV: begin
                if (!(r.par | r.frm | r.noi | r.ovr)) begin
                    if (ring_wr + 6'd1 == ring_rd) ring_rd = ring_rd + 6'd1;
                    line_ring[ring_wr] = r.data;
                    ring_wr = ring_wr + 6'd1;
                end
            end
            REQ_READ: begin
                lim = (r.limit > LIMIT_MAX) ? LIMIT_MAX : r.limit;
                maxb = (lim == 0) ? 0 : int'(lim) - 1;
                n = '0;
                done = 1'b0;
                stop = 1'b0;
                while (!stop && int'(n) < maxb && ring_wr != ring_rd) begin
                    c = line_ring[ring_rd];
                    ring_rd = ring_rd + 6'd1;
                    if (c == CHAR_LF || c == CHAR_CR) begin
                        done = 1'b1;
                        stop = 1'b1;
                    end else begin
                        n = n + 6'd1;
                        line_resp_q.push_back('{c, 1'b1, n, 1'b0, 6'd0, 1'b0});
                    end
                end
                if (n == 0) begin
                    line_resp_q.push_back('{8'd0, 1'b0, 6'd0, done, 6'd0, 1'b1});
                end else begin
                    resp = line_resp_q.pop_back();
                    resp.done = done;
                    resp.last = 1'b1;
                    line_resp_q.push_back(resp);
                end
            end
            REQ_QUERY: begin
                line_resp_q.push_back('{8'd0, 1'b0, 6'd0, 1'b0, ring_wr - ring_rd, 1'b1});
            end
            default: ;
        endcase
    endtask

    // Driver
    always @(posedge i_clk) begin
        rx_req_t r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_buffer('{i_req_type, i_rx_byte, i_parity_err, i_framing_err,
                                 i_noise_err, i_overrun_err, i_line_limit});
                accepted_items++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    r = pending_reqs.pop_front();
                    i_req_type <= r.req;
                    i_rx_byte <= r.data;
                    i_parity_err <= r.par;
                    i_framing_err <= r.frm;
                    i_noise_err <= r.noi;
                    i_overrun_err <= r.ovr;
                    i_line_limit <= r.limit;
                    i_valid <= 1'b1;
                    tx_gap = draw_gap(tx_steady);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && accepted_items >= 70) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            rx_gap = draw_gap(rx_steady);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        line_resp_t got;
        line_resp_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_char, o_char_valid, o_line_count, o_line_done, o_avail_count,
                    o_last};
            if (line_resp_q.size() == 0) begin
                miss_count++;
                if (miss_count <= 10)
                    $display("unexpected: char %h valid %b count %0d done %b avail %0d last %b",
                             got.ch, got.ch_ok, got.count, got.done, got.avail, got.last);
            end else begin
                want = line_resp_q.pop_front();
                if (got !== want) begin
                    miss_count++;
                    if (miss_count <= 10) begin
                        $write("result differs (exp/got): char %h/%h valid %b/%b ",
                               want.ch, got.ch, want.ch_ok, got.ch_ok);
                        $display("count %0d/%0d done %b/%b avail %0d/%0d last %b/%b",
                                 want.count, got.count, want.done, got.done,
                                 want.avail, got.avail, want.last, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_rx_line_buffer: mismatch");
            $finish;
        end
    end

    initial begin
        int pick;
        int len;
        int r;
        logic [3:0] errs;

        // directed: empty ring, error drops, limits, terminators
        push_query();
        push_read(7'd10);
        push_recv(8'h41, 4'b1000);
        push_recv(8'h41, 4'b0100);
        push_recv(8'h41, 4'b0010);
        push_recv(8'h41, 4'b0001);
        push_query();
        push_recv(8'h00, 4'b0000);
        push_recv(8'hFF, 4'b0000);
        push_recv(8'h68, 4'b0000);
        push_recv(CHAR_CR, 4'b0000);
        push_read(7'd127);
        push_recv(CHAR_LF, 4'b0000);
        push_read(7'd5);
        push_recv(8'h78, 4'b0000);
        push_recv(8'h79, 4'b0000);
        push_read(7'd0);
        push_read(7'd1);
        push_read(7'd2);
        push_read(7'd64);
        push_recv(8'h61, 4'b0000);
        push_recv(CHAR_CR, 4'b0000);
        push_read(7'd2);
        push_read(7'd3);
        queue_item('{REQ_NONE, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 7'd9});
        push_query();

        // random: mostly text lines with terminators, then reads and counts
        while (counted_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 90)
                                                   : $urandom_range(0, 12);
                for (int i = 0; i < len; i++) begin
                    errs = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
                    push_recv(text_byte(), errs);
                end
                if ($urandom_range(0, 4) != 0)
                    push_recv($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 4'd0);
                if ($urandom_range(0, 3) == 0) push_query();
                if ($urandom_range(0, 3) != 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) push_read(7'($urandom_range(2, 40)));
                    else if (r < 85) push_read(7'($urandom_range(64, 127)));
                    else push_read(7'($urandom));
                end
            end else if (pick < 78) begin
                push_read(7'($urandom));
            end else if (pick < 88) begin
                push_query();
            end else begin
                queue_item('{2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                             1'($urandom), 1'($urandom), 7'($urandom)});
            end
        end
        push_read(7'd127);
        push_query();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid) @(negedge i_clk);
        while (line_resp_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);

        if (miss_count == 0 && line_resp_q.size() == 0) begin
            $display("uart_rx_line_buffer: match");
        end else begin
            $display("uart_rx_line_buffer: mismatch");
        end
        $finish;
    end

endmodule
